@@ design/hmm_viterbi_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder_top_defines
// Assertion macros used by the decoder back end (hvd_back).
// ----------------------------------------------------------------------------
`ifndef HMM_VITERBI_DECODER_TOP_DEFINES_SVH
`define HMM_VITERBI_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define HVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hvd_pkg.sv @@
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, codes and types of the hidden Markov model Viterbi decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hvd_pkg;

  // capacity
  localparam int MAX_STATES   = 16;
  localparam int MAX_FEATURES = 32;
  localparam int MAX_FRAMES   = 64;

  // index and counter widths
  localparam int ST_W = $clog2(MAX_STATES);
  localparam int SC_W = ST_W + 1;
  localparam int FT_W = $clog2(MAX_FEATURES);
  localparam int FC_W = FT_W + 1;
  localparam int FR_W = $clog2(MAX_FRAMES);
  localparam int FN_W = FR_W + 1;

  // datapath widths
  localparam int VAL_W    = 16;
  localparam int METRIC_W = 16;
  localparam int PROD_W   = 32;
  localparam int SCORE_W  = 40;
  localparam int RAW_W    = 64;
  localparam int SHIFT_W  = $clog2(RAW_W);
  localparam int MSB_POS  = METRIC_W - 1;

  // front queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_PW + 1;

  // opcodes
  localparam logic [1:0] OPC_TRANS = 2'd0;
  localparam logic [1:0] OPC_EMIS  = 2'd1;
  localparam logic [1:0] OPC_FEAT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_STATES   = 2'd0;
  localparam logic [1:0] CFG_NUM_FEATURES = 2'd1;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_TRANS,
    CLS_EMIS,
    CLS_FEAT
  } cls_e;

  typedef struct packed {
    cls_e             cls;
    logic [3:0]       row;
    logic [4:0]       col;
    logic [VAL_W-1:0] value;
    logic             last_feature;
    logic             last_frame;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_RD,
    S_F_AC,
    S_F_END,
    S_R_J,
    S_R_K,
    S_R_CMP,
    S_R_MUL,
    S_R_TOP,
    S_N_FIND,
    S_N_APPLY,
    S_TB_FIND,
    S_TB_SEED,
    S_TB_STEP,
    S_TB_LOAD,
    S_E_RD,
    S_E_OUT
  } bst_e;

endpackage

`default_nettype wire

@@ design/hmm_viterbi_decoder_top.sv @@
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder_top
// Viterbi decoder for a hidden Markov model with soft observation frames.
// ----------------------------------------------------------------------------
// Usage: a command word (opcode, row, col, value, last_feature, last_frame)
// is taken when start_i is high and busy_o is low; a two-word queue sits in
// front of the execution engine, so busy_o rises only when both are held.
// A feature word reads the emission memory and accumulates the score for
// each state in turn, from state 2 up to state 15. A frame end adds the
// recursion, paced by the single transition memory read port, then the
// leading-one search and the renormalization. On the last frame the
// traceback runs, then one result per frame comes out in ascending frame
// order; valid_o marks each result for one cycle.
// The receiver cannot stall; results are simply presented.
// Configuration (num_states, num_features) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while the block is idle.
// Reset clears the sequence state and loads the register defaults; the
// transition and emission tables hold no value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_viterbi_decoder_top import hvd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [3:0]       row_i,
  input  wire logic [4:0]       col_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire logic             last_feature_i,
  input  wire logic             last_frame_i,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [5:0]       cfg_wdata_i,
  output logic                  valid_o,
  output logic [ST_W-1:0]       state_index_o,
  output logic [FR_W-1:0]       frame_index_o,
  output logic                  last_o,
  output logic                  overflow_o
);

  logic [4:0] num_states_q;
  logic [5:0] num_features_q;
  item_t      head;
  logic       head_valid;
  logic       pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q   <= 5'd16;
      num_features_q <= 6'd12;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_STATES:   num_states_q   <= cfg_wdata_i[4:0];
        CFG_NUM_FEATURES: num_features_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hvd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .last_feature_i (last_feature_i),
    .last_frame_i   (last_frame_i),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .pop_i          (pop)
  );

  hvd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .num_states_i   (SC_W'(num_states_q)),
    .num_features_i (FC_W'(num_features_q)),
    .valid_o        (valid_o),
    .state_index_o  (state_index_o),
    .frame_index_o  (frame_index_o),
    .last_o         (last_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire

@@ design/hvd_ram.sv @@
// ----------------------------------------------------------------------------
// hvd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/hvd_front.sv @@
// ----------------------------------------------------------------------------
// hvd_front
// Accepts command words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_front import hvd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [3:0] row_i,
  input  wire logic [4:0] col_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire logic       last_feature_i,
  input  wire logic       last_frame_i,
  output item_t           head_o,
  output logic            head_valid_o,
  input  wire logic       pop_i
);

  item_t               slot_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]  count_q, count_d;
  item_t               cls_item;
  logic                push;

  // classify: out-of-range table writes and unused opcodes become no-ops
  always_comb begin
    cls_item.row          = row_i;
    cls_item.col          = col_i;
    cls_item.value        = value_i;
    cls_item.last_feature = last_feature_i;
    cls_item.last_frame   = last_frame_i;
    case (opcode_i)
      OPC_TRANS: cls_item.cls = (32'(col_i) < MAX_STATES && 32'(row_i) < MAX_STATES)
                                ? CLS_TRANS : CLS_NONE;
      OPC_EMIS:  cls_item.cls = (32'(col_i) < MAX_FEATURES && 32'(row_i) < MAX_STATES)
                                ? CLS_EMIS : CLS_NONE;
      OPC_FEAT:  cls_item.cls = CLS_FEAT;
      default:   cls_item.cls = CLS_NONE;
    endcase
  end

  assign busy_o       = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign push         = start_i && !busy_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  // queue pointers
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + FIFO_CW'(push) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

`default_nettype wire

@@ design/hvd_back.sv @@
// ----------------------------------------------------------------------------
// hvd_back
// Executes queued words: table loads, score accumulation, the per-frame
// max-product recursion with renormalization, and traceback of the path.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hmm_viterbi_decoder_top_defines.svh"

module hvd_back import hvd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire item_t           head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  input  wire logic [SC_W-1:0] num_states_i,
  input  wire logic [FC_W-1:0] num_features_i,
  output logic                 valid_o,
  output logic [ST_W-1:0]      state_index_o,
  output logic [FR_W-1:0]      frame_index_o,
  output logic                 last_o,
  output logic                 overflow_o
);

  bst_e                  state_q, state_d;
  item_t                 item_q, item_d;
  logic [SC_W-1:0]       j_q, j_d, k_q, k_d;
  logic [FC_W-1:0]       feat_q, feat_d;
  logic [FN_W-1:0]       fc_q, fc_d;
  logic [ST_W-1:0]       cb_q, cb_d;
  logic                  ovf_q, ovf_d;
  logic [METRIC_W-1:0]   metric_q [MAX_STATES];
  logic [METRIC_W-1:0]   metric_d [MAX_STATES];
  logic [SCORE_W-1:0]    score_q [MAX_STATES];
  logic [SCORE_W-1:0]    score_d [MAX_STATES];
  logic [RAW_W-1:0]      raw_q [MAX_STATES];
  logic [RAW_W-1:0]      raw_d [MAX_STATES];
  logic [PROD_W-1:0]     pmax_q, pmax_d;
  logic [RAW_W-1:0]      top_q, top_d;
  logic [SHIFT_W-1:0]    b_q, b_d;
  logic [ST_W-1:0]       cur_q, cur_d, best_q, best_d;
  logic [METRIC_W-1:0]   pm_q, pm_d;
  logic [FR_W-1:0]       i_q, i_d;

  logic [SC_W-1:0]       ns;
  logic [FC_W-1:0]       nf;
  logic [ST_W-1:0]       jx;
  logic [VAL_W-1:0]      tr_rdata, em_rdata;
  logic [ST_W-1:0]       bp_rdata, seq_rdata;
  logic                  tr_we, em_we, bp_we, seq_we;
  logic [FR_W-1:0]       seq_waddr;
  logic [ST_W-1:0]       seq_wdata;
  logic [PROD_W-1:0]     prod_f, prod_r;
  logic [SCORE_W:0]      sum_f;
  logic [RAW_W-1:0]      raw_m, shifted;
  logic                  last_res;

  // register limits above capacity act as capacity
  assign ns = (32'(num_states_i) > MAX_STATES) ? SC_W'(MAX_STATES) : num_states_i;
  assign nf = (32'(num_features_i) > MAX_FEATURES) ? FC_W'(MAX_FEATURES) : num_features_i;
  assign jx = j_q[ST_W-1:0];

  // table loads go straight from the queue head
  assign pop_o = (state_q == S_IDLE) && head_valid_i;
  assign tr_we = pop_o && (head_i.cls == CLS_TRANS);
  assign em_we = pop_o && (head_i.cls == CLS_EMIS);

  hvd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_STATES * MAX_STATES)) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i ({head_i.row[ST_W-1:0], head_i.col[ST_W-1:0]}),
    .wdata_i (head_i.value),
    .raddr_i ({k_q[ST_W-1:0], jx}),
    .rdata_o (tr_rdata)
  );

  hvd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_STATES * MAX_FEATURES)) u_em_ram (
    .clk_i   (clk_i),
    .we_i    (em_we),
    .waddr_i ({head_i.row[ST_W-1:0], head_i.col[FT_W-1:0]}),
    .wdata_i (head_i.value),
    .raddr_i ({jx, feat_q[FT_W-1:0]}),
    .rdata_o (em_rdata)
  );

  hvd_ram #(.WIDTH(ST_W), .DEPTH(MAX_FRAMES * MAX_STATES)) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (bp_we),
    .waddr_i ({fc_q[FR_W-1:0], jx}),
    .wdata_i (cb_q),
    .raddr_i ({i_q, cur_q}),
    .rdata_o (bp_rdata)
  );

  hvd_ram #(.WIDTH(ST_W), .DEPTH(MAX_FRAMES)) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (seq_waddr),
    .wdata_i (seq_wdata),
    .raddr_i (i_q),
    .rdata_o (seq_rdata)
  );

  // datapath: feature product, transition candidate, raw metric, normalize shift
  assign prod_f = PROD_W'(item_q.value) * PROD_W'(em_rdata);
  assign sum_f  = (SCORE_W + 1)'(score_q[jx]) + (SCORE_W + 1)'(prod_f);
  assign prod_r = PROD_W'(metric_q[k_q[ST_W-1:0]]) * PROD_W'(tr_rdata);
  assign raw_m  = RAW_W'(pmax_q) * RAW_W'(score_q[jx][SCORE_W-1:8]);

  always_comb begin
    if (b_q >= SHIFT_W'(MSB_POS)) begin
      shifted = raw_q[jx] >> (b_q - SHIFT_W'(MSB_POS));
    end else begin
      shifted = raw_q[jx] << (SHIFT_W'(MSB_POS) - b_q);
    end
  end

  assign last_res      = ({1'b0, i_q} == fc_q - 1'b1);
  assign valid_o       = (state_q == S_E_OUT);
  assign state_index_o = seq_rdata;
  assign frame_index_o = i_q;
  assign last_o        = last_res;
  assign overflow_o    = ovf_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    j_d       = j_q;
    k_d       = k_q;
    feat_d    = feat_q;
    fc_d      = fc_q;
    cb_d      = cb_q;
    ovf_d     = ovf_q;
    metric_d  = metric_q;
    score_d   = score_q;
    raw_d     = raw_q;
    pmax_d    = pmax_q;
    top_d     = top_q;
    b_d       = b_q;
    cur_d     = cur_q;
    best_d    = best_q;
    pm_d      = pm_q;
    i_d       = i_q;
    bp_we     = 1'b0;
    seq_we    = 1'b0;
    seq_waddr = i_q;
    seq_wdata = cur_q;

    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          item_d = head_i;
          if (head_i.cls == CLS_FEAT) begin
            if (feat_q < nf) begin
              j_d     = SC_W'(2);
              state_d = S_F_RD;
            end else begin
              state_d = S_F_END;
            end
          end
        end
      end
      S_F_RD: begin
        state_d = S_F_AC;
      end
      // saturating score accumulate
      S_F_AC: begin
        score_d[jx] = sum_f[SCORE_W] ? {SCORE_W{1'b1}} : sum_f[SCORE_W-1:0];
        if (j_q == SC_W'(MAX_STATES - 1)) begin
          state_d = S_F_END;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_F_RD;
        end
      end
      S_F_END: begin
        if (32'(feat_q) < MAX_FEATURES) begin
          feat_d = feat_q + 1'b1;
        end
        state_d = S_IDLE;
        if (item_q.last_feature) begin
          feat_d = '0;
          if (32'(fc_q) < MAX_FRAMES) begin
            j_d     = '0;
            top_d   = '0;
            state_d = S_R_J;
          end else begin
            ovf_d   = 1'b1;
            score_d = '{default: '0};
            if (item_q.last_frame) begin
              j_d     = '0;
              best_d  = cb_q;
              pm_d    = '0;
              state_d = S_TB_FIND;
            end
          end
        end
      end
      // destination state loop
      S_R_J: begin
        if (j_q == ns) begin
          j_d     = '0;
          b_d     = SHIFT_W'(RAW_W - 1);
          state_d = S_N_FIND;
        end else begin
          k_d     = '0;
          pmax_d  = '0;
          state_d = S_R_K;
        end
      end
      // predecessor loop
      S_R_K: begin
        state_d = (k_q == ns) ? S_R_MUL : S_R_CMP;
      end
      S_R_CMP: begin
        if (prod_r > pmax_q) begin
          pmax_d = prod_r;
          cb_d   = k_q[ST_W-1:0];
        end
        k_d     = k_q + 1'b1;
        state_d = S_R_K;
      end
      S_R_MUL: begin
        raw_d[jx] = raw_m;
        bp_we     = 1'b1;
        state_d   = S_R_TOP;
      end
      S_R_TOP: begin
        if (raw_q[jx] > top_q) begin
          top_d = raw_q[jx];
        end
        j_d     = j_q + 1'b1;
        state_d = S_R_J;
      end
      // leading-one search, one bit a cycle
      S_N_FIND: begin
        if (top_q == '0 || top_q[b_q]) begin
          j_d     = '0;
          state_d = S_N_APPLY;
        end else begin
          b_d = b_q - 1'b1;
        end
      end
      S_N_APPLY: begin
        metric_d[jx] = (j_q < ns && top_q != '0) ? shifted[METRIC_W-1:0] : '0;
        if (j_q == SC_W'(MAX_STATES - 1)) begin
          fc_d    = fc_q + 1'b1;
          score_d = '{default: '0};
          state_d = S_IDLE;
          if (item_q.last_frame) begin
            j_d     = '0;
            best_d  = cb_q;
            pm_d    = '0;
            state_d = S_TB_FIND;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      // final state search
      S_TB_FIND: begin
        if (j_q == ns) begin
          state_d = S_TB_SEED;
        end else begin
          if (metric_q[jx] > pm_q) begin
            pm_d   = metric_q[jx];
            best_d = jx;
          end
          j_d = j_q + 1'b1;
        end
      end
      S_TB_SEED: begin
        if (fc_q == '0) begin
          metric_d    = '{default: '0};
          metric_d[0] = {METRIC_W{1'b1}};
          score_d     = '{default: '0};
          fc_d        = '0;
          feat_d      = '0;
          cb_d        = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end else begin
          seq_we    = 1'b1;
          seq_waddr = FR_W'(fc_q - 1'b1);
          seq_wdata = best_q;
          cur_d     = best_q;
          i_d       = FR_W'(fc_q - 1'b1);
          state_d   = S_TB_STEP;
        end
      end
      // walk backpointers toward frame zero
      S_TB_STEP: begin
        state_d = (i_q == '0) ? S_E_RD : S_TB_LOAD;
      end
      S_TB_LOAD: begin
        cur_d     = bp_rdata;
        seq_we    = 1'b1;
        seq_waddr = i_q - 1'b1;
        seq_wdata = bp_rdata;
        i_d       = i_q - 1'b1;
        state_d   = S_TB_STEP;
      end
      S_E_RD: begin
        state_d = S_E_OUT;
      end
      // one result word, then sequence reset after the last
      S_E_OUT: begin
        if (last_res) begin
          metric_d    = '{default: '0};
          metric_d[0] = {METRIC_W{1'b1}};
          score_d     = '{default: '0};
          fc_d        = '0;
          feat_d      = '0;
          cb_d        = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_E_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      j_q      <= '0;
      k_q      <= '0;
      feat_q   <= '0;
      fc_q     <= '0;
      cb_q     <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      metric_q <= '{0: {METRIC_W{1'b1}}, default: '0};
      score_q  <= '{default: '0};
    end else begin
      state_q  <= state_d;
      j_q      <= j_d;
      k_q      <= k_d;
      feat_q   <= feat_d;
      fc_q     <= fc_d;
      cb_q     <= cb_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      metric_q <= metric_d;
      score_q  <= score_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    raw_q  <= raw_d;
    pmax_q <= pmax_d;
    top_q  <= top_d;
    b_q    <= b_d;
    cur_q  <= cur_d;
    best_q <= best_d;
    pm_q   <= pm_d;
  end

  // checks
  `HVD_ASSERT_NOW(a_res_in_emit, valid_o, !pop_o && state_q == S_E_OUT, "result outside emit")
  `HVD_ASSERT_NEXT(a_last_ends, valid_o && last_o, !valid_o && fc_q == '0, "path did not end")
  `HVD_ASSERT_NOW(a_fc_range, 1'b1, 32'(fc_q) <= MAX_FRAMES, "frame count beyond capacity")

endmodule

`default_nettype wire
